### rtl/assert_macros.svh
// Assertion macros used by the RTL of the clock offset window average block.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define COWA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("cowa: same-cycle check failed");
`define COWA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("cowa: next-cycle check failed");
`else
`define COWA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define COWA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

### rtl/cowa_pkg.sv
// Constants and request codes of the clock offset window average block.
// Depends on nothing.
package cowa_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;
    localparam int SAMPLE_W         = 32;
    localparam int SMOOTH_W         = 36;  // width of 5*old + mean
    localparam int SMOOTH_DIVISOR   = 6;
    localparam int COUNT_OUT_W      = 9;

    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

endpackage

### rtl/clock_offset_window_average_unit.sv
// Sample request: accepted in idle; the window mean comes from the restoring
// divider (one bit per cycle), and the divide by six that follows is a reciprocal
// multiply done in the steps S_LOAD2, S_RCPH, S_RCPL, S_RCPQ and S_FIX.
// Restart request: clears the window and goes straight to S_DONE.
// A new request is taken only in idle, once the last result is in the output register.
// Reset (rst_n, async, active low) clears window count, position, sum and smoothed value.
`include "assert_macros.svh"

module clock_offset_window_average_unit
    import cowa_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [SAMPLE_W-1:0]           server_time,
    input  logic [SAMPLE_W-1:0]           local_time,
    input  logic [SAMPLE_W-1:0]           round_trip,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_W-1:0]    mean_offset,
    output logic signed [SAMPLE_W-1:0]    smoothed_offset,
    output logic [COUNT_OUT_W-1:0]        sample_count
);

    // Derived widths: count, ring index, exact window sum, divider datapath.
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int IW    = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DVW   = (SUM_W > SMOOTH_W) ? SUM_W : SMOOTH_W;
    localparam int DSW   = (CW > 3) ? CW : 3;
    localparam int STW   = $clog2(DVW);

    // Divide by six: |5*old + mean| stays below 2^34, so split it into two
    // 17-bit halves and divide each with a small reciprocal multiply.
    localparam int RCP_PART_W = 17;
    localparam int RCP_IN_W   = 20;
    localparam int RCP_SHIFT  = 23;
    localparam int RCP_MULT_W = 21;
    localparam int RCP_PROD_W = RCP_IN_W + RCP_MULT_W;
    localparam logic [RCP_MULT_W-1:0] RCP_MULT =
        RCP_MULT_W'((2**RCP_SHIFT + SMOOTH_DIVISOR - 1) / SMOOTH_DIVISOR);

    // Sequencer codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUB   = 4'd1;  // drop the oldest sample when full
    localparam logic [3:0] S_ADD   = 4'd2;  // add the new sample, write the ring
    localparam logic [3:0] S_LOAD1 = 4'd3;  // load |sum| / count
    localparam logic [3:0] S_DIV   = 4'd4;  // one quotient bit per cycle
    localparam logic [3:0] S_ROUND = 4'd5;  // round away from zero only past the half
    localparam logic [3:0] S_PREP  = 4'd6;  // form 5*old + mean
    localparam logic [3:0] S_LOAD2 = 4'd7;  // split |5*old + mean| into halves
    localparam logic [3:0] S_FIX   = 4'd8;  // apply sign, truncated toward zero
    localparam logic [3:0] S_DONE  = 4'd9;  // hand the result to the output register
    localparam logic [3:0] S_RCPH  = 4'd10; // quotient of the upper half
    localparam logic [3:0] S_RCPL  = 4'd11; // carry its remainder into the lower half
    localparam logic [3:0] S_RCPQ  = 4'd12; // quotient of the lower half

    logic [3:0]                state_reg, state_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic [CW-1:0]             fill_reg, fill_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] smooth_reg, smooth_next;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic signed [SMOOTH_W-1:0] sdvd_reg, sdvd_next;
    logic [DVW-1:0]            dvd_reg, dvd_next;
    logic [DSW-1:0]            rem_reg, rem_next;
    logic [DSW-1:0]            divisor_reg, divisor_next;
    logic [STW-1:0]            cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;
    logic [RCP_IN_W-1:0]       rcp_in_reg, rcp_in_next;
    logic [RCP_PART_W-1:0]     rcp_hi_reg, rcp_hi_next;
    logic [RCP_PART_W-1:0]     rcp_lo_reg, rcp_lo_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_mean_reg, out_mean_next;
    logic signed [SAMPLE_W-1:0] out_smooth_reg, out_smooth_next;
    logic [COUNT_OUT_W-1:0]    out_count_reg, out_count_next;

    // Offset ring: no reset, an entry is read only after it was written.
    logic [SAMPLE_W-1:0]       ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0]       rd_data_reg;

    logic                      in_take;
    logic                      out_free;
    logic                      full;
    logic [DSW:0]              rem_shift;
    logic [DSW:0]              trial;
    logic                      fits;
    logic [SUM_W-1:0]          sum_mag;
    logic [SMOOTH_W-1:0]       sdvd_mag;
    logic signed [SMOOTH_W-1:0] smooth_ext;
    logic signed [SMOOTH_W-1:0] mean_ext;
    logic                      round_up;
    logic [32:0]               q_round;
    logic [32:0]               q_signed;
    logic [SAMPLE_W-1:0]       q_trunc;
    logic [RCP_PROD_W-1:0]     rcp_prod;
    logic [RCP_PART_W-1:0]     rcp_q;
    logic [RCP_IN_W-1:0]       rcp_rem;
    logic [2*RCP_PART_W-1:0]   rcp_mag;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = (fill_reg == CW'(WINDOW_DEPTH));

    assign mean_offset     = out_mean_reg;
    assign smoothed_offset = out_smooth_reg;
    assign sample_count    = out_count_reg;

    // Restoring divider step: shift in the next dividend bit, try the subtract.
    assign rem_shift = {rem_reg, dvd_reg[DVW-1]};
    assign trial     = rem_shift - {1'b0, divisor_reg};
    assign fits      = !trial[DSW];

    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign sdvd_mag   = sdvd_reg[SMOOTH_W-1] ? SMOOTH_W'(-sdvd_reg) : SMOOTH_W'(sdvd_reg);
    assign smooth_ext = {{(SMOOTH_W-SAMPLE_W){smooth_reg[SAMPLE_W-1]}}, smooth_reg};
    assign mean_ext   = {{(SMOOTH_W-SAMPLE_W){mean_reg[SAMPLE_W-1]}}, mean_reg};

    // Step away from zero only when the remainder is beyond half the count.
    assign round_up = (rem_reg > DSW'(fill_reg >> 1));
    assign q_round  = dvd_reg[32:0] + {32'd0, round_up};
    assign q_signed = neg_reg ? (33'd0 - q_round) : q_round;

    // Reciprocal multiply, exact for operands below 2^20; the remainder of the
    // upper half is below six and becomes the top bits of the lower operand.
    assign rcp_prod = {{(RCP_PROD_W-RCP_IN_W){1'b0}}, rcp_in_reg}
                    * {{(RCP_PROD_W-RCP_MULT_W){1'b0}}, RCP_MULT};
    assign rcp_q    = rcp_prod[RCP_SHIFT +: RCP_PART_W];
    assign rcp_rem  = rcp_in_reg - RCP_IN_W'(SMOOTH_DIVISOR)
                    * {{(RCP_IN_W-RCP_PART_W){1'b0}}, rcp_hi_reg};
    assign rcp_mag  = {rcp_hi_reg, rcp_lo_reg};
    assign q_trunc  = neg_reg ? (SAMPLE_W'(0) - rcp_mag[SAMPLE_W-1:0])
                              : rcp_mag[SAMPLE_W-1:0];

    // The count port is the fill count masked to its field width.
    assign count_ext = {{COUNT_OUT_W{1'b0}}, fill_reg};

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        smooth_next     = smooth_reg;
        mean_next       = mean_reg;
        sdvd_next       = sdvd_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        rcp_in_next     = rcp_in_reg;
        rcp_hi_next     = rcp_hi_reg;
        rcp_lo_next     = rcp_lo_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_mean_next   = out_mean_reg;
        out_smooth_next = out_smooth_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (req_type == REQ_RESTART)
                    begin
                        pos_next    = '0;
                        fill_next   = '0;
                        sum_next    = '0;
                        smooth_next = '0;
                        mean_next   = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        sample_next = server_time + (round_trip >> 1) - local_time;
                        state_next  = S_SUB;
                    end
                end
            end
            S_SUB:
            begin
                if (full)
                begin
                    sum_next = sum_reg
                             - {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next = sum_reg
                         + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
                if (!full)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                pos_next   = (pos_reg == IW'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + IW'(1);
                state_next = S_LOAD1;
            end
            S_LOAD1:
            begin
                // Left-align the magnitude so only SUM_W steps are needed.
                dvd_next     = DVW'(sum_mag) << (DVW - SUM_W);
                rem_next     = '0;
                divisor_next = DSW'(fill_reg);
                cnt_next     = STW'(SUM_W - 1);
                neg_next     = sum_reg[SUM_W-1];
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                dvd_next = {dvd_reg[DVW-2:0], fits};
                rem_next = fits ? trial[DSW-1:0] : rem_shift[DSW-1:0];
                cnt_next = cnt_reg - STW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                mean_next  = q_signed[SAMPLE_W-1:0];
                state_next = S_PREP;
            end
            S_PREP:
            begin
                sdvd_next  = (smooth_ext <<< 2) + smooth_ext + mean_ext;
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                rcp_in_next = {{(RCP_IN_W-RCP_PART_W){1'b0}},
                               sdvd_mag[2*RCP_PART_W-1:RCP_PART_W]};
                rcp_lo_next = sdvd_mag[RCP_PART_W-1:0];
                neg_next    = sdvd_reg[SMOOTH_W-1];
                state_next  = S_RCPH;
            end
            S_RCPH:
            begin
                rcp_hi_next = rcp_q;
                state_next  = S_RCPL;
            end
            S_RCPL:
            begin
                rcp_in_next = {rcp_rem[RCP_IN_W-RCP_PART_W-1:0], rcp_lo_reg};
                state_next  = S_RCPQ;
            end
            S_RCPQ:
            begin
                // The lower quotient stays below 2^17, so the halves just concatenate.
                rcp_lo_next = rcp_q;
                state_next  = S_FIX;
            end
            S_FIX:
            begin
                smooth_next = q_trunc;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_mean_next   = mean_reg;
                    out_smooth_next = smooth_reg;
                    out_count_next  = count_ext[COUNT_OUT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        mean_reg       <= mean_next;
        sdvd_reg       <= sdvd_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        cnt_reg        <= cnt_next;
        neg_reg        <= neg_next;
        rcp_in_reg     <= rcp_in_next;
        rcp_hi_reg     <= rcp_hi_next;
        rcp_lo_reg     <= rcp_lo_next;
        out_mean_reg   <= out_mean_next;
        out_smooth_reg <= out_smooth_next;
        out_count_reg  <= out_count_next;
    end

    // Ring: write the new sample, read the oldest entry at the write position.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD)
        begin
            ring[pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring[pos_reg];
    end

    `COWA_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CW'(WINDOW_DEPTH))
    `COWA_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == S_DIV, divisor_reg != '0)
    `COWA_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_take, state_reg != S_IDLE)
    `COWA_ASSERT_NXT(a_restart_clears, clk, rst_n, in_take && (req_type == REQ_RESTART), (fill_reg == '0) && (sum_reg == '0) && (smooth_reg == '0))
    `COWA_ASSERT_NXT(a_add_fills, clk, rst_n, state_reg == S_ADD, fill_reg != '0)

endmodule

### tb/cowa_checker.sv
// Scoreboard for the clock offset window average unit: watches both channels,
// predicts each result from the accepted requests and compares it field by field.
// Depends on cowa_pkg for widths, request codes and the smoothing divisor.
module cowa_checker
    import cowa_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       req_type,
    input  logic [SAMPLE_W-1:0]        server_time,
    input  logic [SAMPLE_W-1:0]        local_time,
    input  logic [SAMPLE_W-1:0]        round_trip,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] mean_offset,
    input  logic signed [SAMPLE_W-1:0] smoothed_offset,
    input  logic [COUNT_OUT_W-1:0]     sample_count,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);

    localparam longint SMOOTH_OLD_WEIGHT = 5;
    localparam int     DUE_DEPTH         = 8;   // the unit holds at most two requests

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] smooth;
        logic [COUNT_OUT_W-1:0]     count;
    } offset_estimate_t;

    // Shadow copy of the window state
    logic [SAMPLE_W-1:0] offset_window [WINDOW_DEPTH];
    int                  write_slot;
    longint              fill;
    longint              window_total;
    longint              smooth_acc;

    // Expected results in request order
    offset_estimate_t    estimates_due [DUE_DEPTH];
    int                  due_wr;
    int                  due_rd;
    int                  due_count;

    // Fold one accepted request into the shadow state and return its result.
    function automatic offset_estimate_t fold_request(logic kind, logic [SAMPLE_W-1:0] srv,
                                                      logic [SAMPLE_W-1:0] loc,
                                                      logic [SAMPLE_W-1:0] rtt);
        offset_estimate_t    est;
        logic [SAMPLE_W-1:0] raw;
        longint              q;
        longint              r;
        est = '0;
        if (kind == REQ_RESTART)
        begin
            write_slot   = 0;
            fill         = 0;
            window_total = 0;
            smooth_acc   = 0;
            return est;
        end
        raw = srv + (rtt >> 1) - loc;
        // full window: the oldest sample leaves the sum
        if (fill >= WINDOW_DEPTH)
            window_total -= longint'($signed(offset_window[write_slot]));
        else
            fill++;
        offset_window[write_slot] = raw;
        window_total += longint'($signed(raw));
        write_slot = (write_slot + 1) % WINDOW_DEPTH;
        // mean truncated toward zero, then one step away from zero past the half
        q = window_total / fill;
        r = window_total % fill;
        if (r < 0)
            r = -r;
        if (r > fill / 2)
            q += (window_total < 0) ? -1 : 1;
        smooth_acc = (smooth_acc * SMOOTH_OLD_WEIGHT + q) / SMOOTH_DIVISOR;
        est.mean   = q[SAMPLE_W-1:0];
        est.smooth = smooth_acc[SAMPLE_W-1:0];
        est.count  = fill[COUNT_OUT_W-1:0];
        return est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        offset_estimate_t want;
        if (!rst_n)
        begin
            write_slot   = 0;
            fill         = 0;
            window_total = 0;
            smooth_acc   = 0;
            due_wr       = 0;
            due_rd       = 0;
            due_count    = 0;
            fail_count   = 0;
            checked      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                estimates_due[due_wr] = fold_request(req_type, server_time, local_time,
                                                     round_trip);
                due_wr = (due_wr + 1) % DUE_DEPTH;
                due_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (due_count == 0)
                begin
                    $display("%0t unexpected result: expected none, got mean %0d smooth %0d count %0d",
                             $time, mean_offset, smoothed_offset, sample_count);
                    fail_count++;
                end
                else
                begin
                    want = estimates_due[due_rd];
                    due_rd = (due_rd + 1) % DUE_DEPTH;
                    due_count--;
                    checked++;
                    if (mean_offset !== want.mean)
                    begin
                        $display("%0t mean_offset: expected %0d, got %0d",
                                 $time, want.mean, mean_offset);
                        fail_count++;
                    end
                    if (smoothed_offset !== want.smooth)
                    begin
                        $display("%0t smoothed_offset: expected %0d, got %0d",
                                 $time, want.smooth, smoothed_offset);
                        fail_count++;
                    end
                    if (sample_count !== want.count)
                    begin
                        $display("%0t sample_count: expected %0d, got %0d",
                                 $time, want.count, sample_count);
                        fail_count++;
                    end
                end
            end
        end
        pending = due_count;
    end

endmodule

### tb/tb_top.sv
// Top of the clock offset window average testbench: clock, reset, request
// stimulus, result back-pressure and the final verdict.
// Depends on cowa_pkg, the clock_offset_window_average_unit RTL and cowa_checker.
module tb_top;
    import cowa_pkg::*;

    localparam int ITEM_COUNT  = 700;
    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int SETTLE      = 120;   // beyond the longest sample latency

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic                       req_type        = REQ_ADD;
    logic [SAMPLE_W-1:0]        server_time     = '0;
    logic [SAMPLE_W-1:0]        local_time      = '0;
    logic [SAMPLE_W-1:0]        round_trip      = '0;
    logic                       out_valid;
    logic                       out_stall       = 1'b0;
    logic signed [SAMPLE_W-1:0] mean_offset;
    logic signed [SAMPLE_W-1:0] smoothed_offset;
    logic [COUNT_OUT_W-1:0]     sample_count;

    int fail_count;
    int pending;
    int checked;

    // Shared between the sender and the receiver process
    bit quiet      = 1'b0;     // no idle cycles on either side
    bit hold_out   = 1'b0;     // ask the receiver for one long hold-off

    int sent_count    = 0;
    int restart_count = 0;
    int run_length    = 0;     // samples since the last restart
    int longest_run   = 0;

    always #5 clk = ~clk;

    clock_offset_window_average_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .server_time     (server_time),
        .local_time      (local_time),
        .round_trip      (round_trip),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_offset     (mean_offset),
        .smoothed_offset (smoothed_offset),
        .sample_count    (sample_count)
    );

    cowa_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .server_time     (server_time),
        .local_time      (local_time),
        .round_trip      (round_trip),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_offset     (mean_offset),
        .smoothed_offset (smoothed_offset),
        .sample_count    (sample_count),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    // Offer one request and hold it until the unit takes it. Idle cycles come
    // first, with valid low, so the payload never changes under a stall.
    task automatic send_request(logic kind, logic [SAMPLE_W-1:0] srv,
                                logic [SAMPLE_W-1:0] loc, logic [SAMPLE_W-1:0] rtt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        server_time <= srv;
        local_time  <= loc;
        round_trip  <= rtt;
        // in_stall read right after the edge is the value the unit saw there
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        if (kind == REQ_RESTART)
        begin
            restart_count++;
            run_length = 0;
        end
        else
        begin
            run_length++;
            if (run_length > longest_run)
                longest_run = run_length;
        end
    endtask

    // Add a sample whose offset is exactly off, from a random time base.
    task automatic send_offset(int off);
        logic [SAMPLE_W-1:0] base;
        base = $urandom;
        send_request(REQ_ADD, base + off, base, '0);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: stall each result for a random hold-off, and once for a long stretch
    // so the unit fills up and has to stall its input.
    initial
    begin
        int hold;
        bit long_hold_done;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_out && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] srv;
        logic [SAMPLE_W-1:0] loc;
        logic [SAMPLE_W-1:0] rtt;
        int                  kind;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: restart on an empty window, rounding at and past the half
        // for both signs, odd round trip halving, and the extremes of every field.
        send_request(REQ_RESTART, '0, '0, '0);
        send_offset(1);
        send_offset(2);               // 3/2: exact half, even count, stays at 1
        send_offset(2);               // 5/3: past the half, rounds up to 2
        send_request(REQ_RESTART, '1, '1, '1);
        send_offset(-1);
        send_offset(-2);              // -3/2: stays at -1
        send_offset(-2);              // -5/3: rounds to -2
        send_request(REQ_ADD, '0, '0, 32'd7);            // odd round trip truncates
        send_request(REQ_ADD, '0, '0, '1);               // largest positive offset
        send_request(REQ_ADD, '0, 32'h8000_0000, '0);    // most negative offset
        send_request(REQ_ADD, '1, '0, '1);
        send_request(REQ_ADD, '0, '1, '0);
        send_request(REQ_ADD, '0, '0, '0);
        send_request(REQ_ADD, '1, '1, '1);
        send_request(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE);
        send_request(REQ_RESTART, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        send_offset(0);
        drain_results();

        // Random: mostly near-synchronous clocks with small jitter, some wild
        // timestamps and extremes. The first few hundred carry no restart so
        // the window fills and wraps.
        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            quiet = (i >= 200 && i < 280) || (i >= 600 && i < 640);
            if (i == 150)
                hold_out = 1'b1;
            if (i == 420)
                drain_results();
            if (i >= 300 && $urandom_range(0, 127) == 0)
            begin
                send_request(REQ_RESTART, $urandom, $urandom, $urandom);
                continue;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                base = $urandom;
                srv  = base + $urandom_range(0, 2000) - 32'd1000;
                loc  = base;
                rtt  = $urandom_range(0, 400);
            end
            else if (kind <= 8)
            begin
                srv = $urandom;
                loc = $urandom;
                rtt = $urandom;
            end
            else
            begin
                srv = $urandom_range(0, 1) ? '1 : '0;
                loc = $urandom_range(0, 1) ? '1 : '0;
                rtt = $urandom_range(0, 1) ? '1 : '0;
            end
            send_request(REQ_ADD, srv, loc, rtt);
        end

        // Hold until nothing is outstanding, then give stray results time to show.
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d requests, %0d of them restarts; longest sample run %0d (depth %0d).",
                 sent_count, restart_count, longest_run, WINDOW_DEPTH_DEF);
        $display("Compared %0d results, %0d mismatches.", checked, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/cowa_pkg.sv
rtl/clock_offset_window_average_unit.sv
tb/cowa_checker.sv
tb/tb_top.sv
